// ===== sv/glyph_address_lookup_top_macros.svh =====
// ----------------------------------------------------------------------------
// glyph_address_lookup_top_macros.svh
// Assertion macros for the glyph address lookup block.
// ----------------------------------------------------------------------------
`ifndef GLYPH_ADDRESS_LOOKUP_TOP_MACROS_SVH
`define GLYPH_ADDRESS_LOOKUP_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked while out of reset
`define GAL_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("glyph lookup check failed");
// next-cycle implication, checked while out of reset
`define GAL_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("glyph lookup check failed");
`else
`define GAL_ASSERT_IMPL(name, pre, post)
`define GAL_ASSERT_NEXT(name, pre, post)
`endif

`endif

// ===== sv/gal_pkg.sv =====
// ----------------------------------------------------------------------------
// gal_pkg
// Shared types, codes and helpers of the glyph address lookup block.
// ----------------------------------------------------------------------------
package gal_pkg;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [15:0] NARROW_LIMIT  = 16'h00DF;
  localparam logic [15:0] FOLD_START    = 16'h00A1;
  localparam logic [15:0] FOLD_TARGET   = 16'h007F;
  localparam logic [31:0] FALLBACK_ADDR = 32'd3040;

  localparam logic [1:0] W_NARROW = 2'd1;
  localparam logic [1:0] W_WIDE   = 2'd2;

  // wide glyph is 32 bytes
  localparam int WIDE_SHIFT = 5;

  typedef enum logic [1:0] {
    K_LOAD,
    K_NARROW,
    K_WIDE
  } kind_t;

  // one queued item: code holds entry_code for loads, query_code otherwise
  typedef struct packed {
    kind_t       kind;
    logic [12:0] position;
    logic [15:0] code;
  } job_t;

  // codes from 0xA1 follow 0x7E, then (code - 1) * 16 with 32-bit wrap
  function automatic logic [31:0] narrow_address(input logic [15:0] code);
    logic [15:0] folded;
    folded = (code >= FOLD_START) ? (code - FOLD_START + FOLD_TARGET) : code;
    return ({16'h0000, folded} - 32'd1) << 4;
  endfunction

endpackage

// ===== sv/gal_front.sv =====
// ----------------------------------------------------------------------------
// gal_front
// Accepts input items, classifies them and pushes them, except out-of-range loads, into the job queue.
// ----------------------------------------------------------------------------
module gal_front import gal_pkg::*; #(
  parameter int TABLE_DEPTH = 8192
) (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [12:0] entry_position,
  input  logic [15:0] entry_code,
  input  logic [15:0] query_code,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic accept;
  logic drop;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // loads past the table end are taken and discarded
  assign drop   = (command == CMD_LOAD) && (32'(entry_position) >= TABLE_DEPTH);
  assign q_push = accept && !drop;

  always_comb begin
    q_job.position = entry_position;
    if (command == CMD_LOAD) begin
      q_job.kind = K_LOAD;
      q_job.code = entry_code;
    end else if (query_code <= NARROW_LIMIT) begin
      q_job.kind = K_NARROW;
      q_job.code = query_code;
    end else begin
      q_job.kind = K_WIDE;
      q_job.code = query_code;
    end
  end

endmodule

// ===== sv/gal_queue.sv =====
// ----------------------------------------------------------------------------
// gal_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module gal_queue import gal_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  output logic valid,
  input  logic pop,
  output job_t pop_job
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  job_t           slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;

  assign full    = (count == (PW+1)'(DEPTH));
  assign valid   = (count != '0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/gal_back.sv =====
// ----------------------------------------------------------------------------
// gal_back
// Holds the index table, computes narrow addresses, runs the binary search and drives the result item.
// ----------------------------------------------------------------------------
module gal_back import gal_pkg::*; #(
  parameter int TABLE_DEPTH = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_pop,
  input  job_t        q_job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] byte_address,
  output logic [1:0]  glyph_width_bytes,
  output logic        found
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW:0] DEPTH_W = (AW+1)'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_DONE
  } state_t;

  state_t state;

  logic [15:0]   mem [TABLE_DEPTH];
  logic [15:0]   rdata;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          mem_we;

  // search bounds: lo and one past hi
  logic [AW:0]   lo;
  logic [AW:0]   hip1;
  logic [AW-1:0] probe;
  logic          first;
  logic [15:0]   code;

  logic [31:0]   res_addr;
  logic [1:0]    res_width;
  logic          res_found;

  logic          eq;
  logic          gt;
  logic [AW:0]   lo_u;
  logic [AW:0]   hp_u;
  logic          empty;
  logic [AW:0]   span;
  logic [AW:0]   mid_full;
  logic [AW-1:0] mid;
  logic          out_load;

  assign q_pop   = (state == S_IDLE) && q_valid;
  assign mem_we  = q_pop && (q_job.kind == K_LOAD);
  assign wr_addr = AW'(q_job.position);

  // result register takes a new item when it is empty or being drained
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // probe compare; position 0 is checked before the bounds start to move
  assign eq   = (rdata == code);
  assign gt   = (rdata > code);
  assign lo_u = (first || gt) ? lo : ({1'b0, probe} + 1'b1);
  assign hp_u = (!first && gt) ? {1'b0, probe} : hip1;
  assign empty    = (lo_u >= hp_u);
  assign span     = hp_u - lo_u - 1'b1;
  assign mid_full = lo_u + (span >> 1);
  assign mid      = mid_full[AW-1:0];

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = '0;
      S_CMP:   rd_addr = mid;
      default: rd_addr = probe;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= q_job.code;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_job.kind)
              K_NARROW: begin
                res_addr  <= narrow_address(q_job.code);
                res_width <= W_NARROW;
                res_found <= 1'b1;
                state     <= S_DONE;
              end
              K_WIDE: begin
                code  <= q_job.code;
                lo    <= '0;
                hip1  <= DEPTH_W;
                probe <= '0;
                first <= 1'b1;
                state <= S_CMP;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CMP: begin
          if (eq) begin
            res_addr  <= 32'(probe) << WIDE_SHIFT;
            res_width <= W_WIDE;
            res_found <= 1'b1;
            state     <= S_DONE;
          end else if (empty) begin
            res_addr  <= FALLBACK_ADDR;
            res_width <= W_WIDE;
            res_found <= 1'b0;
            state     <= S_DONE;
          end else begin
            lo    <= lo_u;
            hip1  <= hp_u;
            probe <= mid;
            first <= 1'b0;
          end
        end
        S_DONE: begin
          if (out_load) begin
            byte_address      <= res_addr;
            glyph_width_bytes <= res_width;
            found             <= res_found;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/glyph_address_lookup_top.sv =====
// ----------------------------------------------------------------------------
// glyph_address_lookup_top
// Maps a character code to the byte address of its glyph in a font store.
// ----------------------------------------------------------------------------
//
// Channel  Handshake             Payload
// -------  --------------------  -----------------------------------------------
// in       in_valid / in_ready   command, entry_position, entry_code, query_code
// out      out_valid / out_ready byte_address, glyph_width_bytes, found
//
// Sequence: a load writes the table as it leaves the queue. A narrow
//   lookup passes from the queue through S_DONE to the output register.
//   A wide lookup binary-searches in S_CMP, one compare per cycle, set by
//   the single read port of the index table, then passes through S_DONE.
// Reset: rst clears the queue and sequencer; the table is not cleared and
//   must be written before it is searched.
// Stalls: a two-entry queue parts front and back, so items are taken while
//   a result waits on out_ready; in_ready drops only when the queue is full.
//
module glyph_address_lookup_top import gal_pkg::*; #(
  parameter int TABLE_DEPTH = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [12:0] entry_position,
  input  logic [15:0] entry_code,
  input  logic [15:0] query_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] byte_address,
  output logic [1:0]  glyph_width_bytes,
  output logic        found
);

`include "glyph_address_lookup_top_macros.svh"

  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  job_t push_job;
  job_t pop_job;

  // front: accept and classify
  gal_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .entry_position(entry_position),
    .entry_code    (entry_code),
    .query_code    (query_code),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  gal_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(push_job),
    .full    (q_full),
    .valid   (q_valid),
    .pop     (q_pop),
    .pop_job (pop_job)
  );

  // back: table writes, search and result register
  gal_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_job            (pop_job),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .byte_address     (byte_address),
    .glyph_width_bytes(glyph_width_bytes),
    .found            (found)
  );

  // width code is only ever narrow or wide
  `GAL_ASSERT_IMPL(a_width_code, out_valid,
                   glyph_width_bytes == W_NARROW || glyph_width_bytes == W_WIDE)
  // narrow glyphs always count as found
  `GAL_ASSERT_IMPL(a_narrow_found, out_valid && glyph_width_bytes == W_NARROW, found)
  // a miss carries the fallback address of a wide glyph
  `GAL_ASSERT_IMPL(a_miss_fallback, out_valid && !found,
                   byte_address == FALLBACK_ADDR && glyph_width_bytes == W_WIDE)
  // a pushed job is visible to the back end on the next cycle
  `GAL_ASSERT_NEXT(a_push_visible, q_push, q_valid)

endmodule
